@@ hdl/sactf_pkg.sv @@
// ----------------------------------------------------------------------------
// sactf_pkg
// Word types and fixed widths shared by the cache tag store and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sactf_pkg;

   localparam int ADDR_PORT_W = 32;
   localparam int WAY_OUT_W   = 4;

   typedef struct packed {
      logic [ADDR_PORT_W-1:0] lookup_addr;
   } req_word_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 upper_half;
      logic                 evicted_valid;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ hdl/sactf_if.sv @@
// ----------------------------------------------------------------------------
// sactf_req_if / sactf_rsp_if
// Valid/ready channels carrying lookup requests and lookup results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sactf_req_if;
   logic                      valid;
   logic                      ready;
   sactf_pkg::req_word_type   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sactf_rsp_if;
   logic                      valid;
   logic                      ready;
   sactf_pkg::rsp_word_type   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/sactf_ram.sv @@
// ----------------------------------------------------------------------------
// sactf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sactf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/set_assoc_cache_tags_fifo_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tags_fifo_top
// Tag store of a set-associative cache with round-robin (fifo) replacement.
//
// req_if carries one byte address per word. The address is split into line
// offset, set index and tag; the tag is compared against every valid way of
// the set. rsp_if returns one word per request: hit, the way that hit or was
// filled, whether the offset lies in the upper half of the line, and whether
// a miss replaced a valid line.
// Each set lives in one row of a single RAM (all tags, valid bits and the
// fill pointer), so a lookup is a read in the accept cycle and a
// compare/write-back in the lookup state, one word at a time.
// The result word sits in an output register; the next request is accepted
// while it waits. If the receiver stalls and the register is still full, the
// lookup holds its write-back until the register frees.
// After reset the block sweeps every set to clear valid bits and pointers,
// one set per cycle, and accepts no request meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tags_fifo_top #(
   parameter int WAYS             = 16,
   parameter int SET_BITS         = 6,
   parameter int LINE_OFFSET_BITS = 6,
   parameter int ADDRESS_BITS     = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sactf_req_if.sink   req_if,
   sactf_rsp_if.source rsp_if
);

   localparam int SETS     = 1 << SET_BITS;
   localparam int WAY_W    = $clog2(WAYS);
   localparam int TAG_W    = ADDRESS_BITS - LINE_OFFSET_BITS - SET_BITS;
   localparam int TAGS_W   = WAYS * TAG_W;
   localparam int ROW_W    = TAGS_W + WAYS + WAY_W;
   localparam int EXT_W    = ADDRESS_BITS + sactf_pkg::ADDR_PORT_W;
   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
   localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(SETS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [SET_BITS-1:0]     clr_idx_ff, clr_idx_in;
   logic [SET_BITS-1:0]     set_ff, set_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic                    upper_ff, upper_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sactf_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic [EXT_W-1:0]        addr_ext;
   logic [ADDRESS_BITS-1:0] addr;
   logic                    accept;
   logic                    go;

   logic                    ram_wr_en;
   logic [SET_BITS-1:0]     ram_wr_addr;
   logic [ROW_W-1:0]        ram_wr_data;
   logic [ROW_W-1:0]        row;

   logic [TAG_W-1:0]        row_tag [WAYS];
   logic [WAYS-1:0]         row_valid;
   logic [WAY_W-1:0]        row_ptr;

   logic                    hit;
   logic [WAY_W-1:0]        hit_way;
   logic                    full;
   logic [WAY_W-1:0]        free_way;
   logic [WAY_W-1:0]        sel_way;
   logic [WAY_W-1:0]        new_ptr;
   logic [TAGS_W-1:0]       new_tags;
   logic [WAYS-1:0]         new_valid;

   // address masked to ADDRESS_BITS, zero-extended when wider than the port
   assign addr_ext = {ADDRESS_BITS'(0), req_if.data.lookup_addr};
   assign addr     = addr_ext[ADDRESS_BITS-1:0];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign go           = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_if.ready);

   sactf_ram #(
      .WIDTH(ROW_W),
      .DEPTH(SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (addr[LINE_OFFSET_BITS +: SET_BITS]),
      .rd_data (row)
   );

   // unpack the set row
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         row_tag[w] = row[w*TAG_W +: TAG_W];
      end
      row_valid = row[TAGS_W +: WAYS];
      row_ptr   = row[TAGS_W+WAYS +: WAY_W];
   end

   // lowest matching way and lowest empty way
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_valid[w] && (row_tag[w] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!row_valid[w]) begin
            free_way = WAY_W'(w);
         end
      end
      full = &row_valid;
   end

   always_comb begin
      if (hit) begin
         sel_way = hit_way;
      end else if (!full) begin
         sel_way = free_way;
      end else begin
         sel_way = row_ptr;
      end

      // pointer moves only when a full set replaces a line
      if (!hit && full) begin
         new_ptr = (row_ptr == LAST_WAY) ? '0 : row_ptr + 1'b1;
      end else begin
         new_ptr = row_ptr;
      end

      new_tags  = row[TAGS_W-1:0];
      new_valid = row_valid;
      for (int w = 0; w < WAYS; w++) begin
         if (sel_way == WAY_W'(w)) begin
            new_tags[w*TAG_W +: TAG_W] = tag_ff;
            new_valid[w]               = 1'b1;
         end
      end
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = go && !hit;
         ram_wr_addr = set_ff;
         ram_wr_data = {new_ptr, new_valid, new_tags};
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      upper_in     = upper_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               set_in   = addr[LINE_OFFSET_BITS +: SET_BITS];
               tag_in   = addr[ADDRESS_BITS-1 -: TAG_W];
               upper_in = addr[LINE_OFFSET_BITS-1];
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (go) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.hit           = hit;
               rsp_data_in.way           = sactf_pkg::WAY_OUT_W'(sel_way);
               rsp_data_in.upper_half    = upper_ff;
               rsp_data_in.evicted_valid = !hit && full;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      upper_ff    <= upper_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the set-associative cache tag store with fifo replacement.
// A short table of directed lookups covers the address extremes, the
// half-line boundary, a set filled to every way and the first evictions.
// A randomized run follows. Most of its addresses fall on a few sets with a
// small pool of tags, so the sets fill, hit and evict many times over and the
// fill pointer wraps. The rest are fully random addresses. Every result is
// checked field by field against a typed row's word or a scoreboard-side
// model of the tag store. Sender gaps and receiver stalls change per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_SETS = 64;
   localparam int NUM_WAYS = 16;
   localparam int LINE_W   = 6;
   localparam int SET_W    = 6;
   localparam int TAG_W    = 20;
   localparam int PHASE_WORDS = 231;

   typedef sactf_pkg::rsp_word_type rsp_word_type;

   typedef struct {
      logic [31:0]  addr;
      bit           typed;
      rsp_word_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   sactf_req_if req_if ();
   sactf_rsp_if rsp_if ();

   set_assoc_cache_tags_fifo_top #(
      .WAYS             (NUM_WAYS),
      .SET_BITS         (SET_W),
      .LINE_OFFSET_BITS (LINE_W),
      .ADDRESS_BITS     (32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #1 clock = ~clock;

   // model of the tag store
   logic [NUM_WAYS-1:0] way_valid [NUM_SETS];
   logic [TAG_W-1:0]    way_tag   [NUM_SETS][NUM_WAYS];
   logic [3:0]          fill_ptr  [NUM_SETS];

   rsp_word_type pending_lookups [$];
   dir_row_type  dir_rows [$];
   logic [TAG_W-1:0] tag_pool [24];
   logic [SET_W-1:0] hot_sets [4] = '{6'd0, 6'd1, 6'd2, 6'd63};

   int err_cnt       = 0;
   int rsp_cnt       = 0;
   int req_idle_pct  = 0;
   int rcv_stall_pct = 0;

   task automatic report_mismatch(input string msg);
      err_cnt++;
      $display("mismatch at %0t ns, word %0d: %s", $time, rsp_cnt, msg);
   endtask

   // hit: lowest matching valid way; miss: lowest empty way, else the pointer
   function automatic rsp_word_type predict_lookup(input logic [31:0] addr);
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
      rsp_word_type     r;
      int               sel;
      set_idx = addr[LINE_W +: SET_W];
      tag     = addr[31 -: TAG_W];
      r       = '0;
      sel     = -1;
      for (int w = 0; w < NUM_WAYS; w++)
         if (sel < 0 && way_valid[set_idx][w] && way_tag[set_idx][w] == tag)
            sel = w;
      if (sel >= 0) begin
         r.hit = 1'b1;
      end else begin
         for (int w = 0; w < NUM_WAYS; w++)
            if (sel < 0 && !way_valid[set_idx][w])
               sel = w;
         if (sel < 0) begin
            sel = fill_ptr[set_idx];
            fill_ptr[set_idx] = fill_ptr[set_idx] + 4'd1;  // wraps at 16 ways
            r.evicted_valid = 1'b1;
         end
         way_tag[set_idx][sel]   = tag;
         way_valid[set_idx][sel] = 1'b1;
      end
      r.way        = sel[3:0];
      r.upper_half = addr[LINE_W-1];
      return r;
   endfunction

   function automatic logic [31:0] pick_addr();
      logic [31:0] a;
      a = $urandom;
      if ($urandom_range(9) < 8) begin
         a[LINE_W +: SET_W] = hot_sets[$urandom_range(3)];
         a[31 -: TAG_W]     = tag_pool[$urandom_range(23)];
      end
      return a;
   endfunction

   task automatic send_lookup(input logic [31:0] addr, input bit typed,
                              input rsp_word_type want);
      rsp_word_type pred;
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.data.lookup_addr <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pred = predict_lookup(addr);
      pending_lookups.push_back(typed ? want : pred);
   endtask

   // result side: check accepted words, then roll the stall for the next edge
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_lookups.size() == 0) begin
               report_mismatch("result word with none expected");
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_if.data.hit !== want.hit)
                  report_mismatch($sformatf("hit %b, want %b",
                                            rsp_if.data.hit, want.hit));
               if (rsp_if.data.way !== want.way)
                  report_mismatch($sformatf("way %0d, want %0d",
                                            rsp_if.data.way, want.way));
               if (rsp_if.data.upper_half !== want.upper_half)
                  report_mismatch($sformatf("upper_half %b, want %b",
                                            rsp_if.data.upper_half, want.upper_half));
               if (rsp_if.data.evicted_valid !== want.evicted_valid)
                  report_mismatch($sformatf("evicted_valid %b, want %b",
                                            rsp_if.data.evicted_valid,
                                            want.evicted_valid));
            end
            rsp_cnt++;
         end
         rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      for (int s = 0; s < NUM_SETS; s++) begin
         way_valid[s] = '0;
         fill_ptr[s]  = '0;
         for (int w = 0; w < NUM_WAYS; w++)
            way_tag[s][w] = '0;
      end
      foreach (tag_pool[k])
         tag_pool[k] = TAG_W'($urandom);

      // extremes and the half-line boundary; fields are hit, way, upper, evicted
      dir_rows.push_back('{32'h0000_0000, 1'b1, rsp_word_type'{1'b0, 4'd0, 1'b0, 1'b0}});
      dir_rows.push_back('{32'h0000_003F, 1'b1, rsp_word_type'{1'b1, 4'd0, 1'b1, 1'b0}});
      dir_rows.push_back('{32'h0000_0020, 1'b1, rsp_word_type'{1'b1, 4'd0, 1'b1, 1'b0}});
      dir_rows.push_back('{32'h0000_001F, 1'b1, rsp_word_type'{1'b1, 4'd0, 1'b0, 1'b0}});
      dir_rows.push_back('{32'hFFFF_FFFF, 1'b1, rsp_word_type'{1'b0, 4'd0, 1'b1, 1'b0}});
      dir_rows.push_back('{32'hFFFF_FFC0, 1'b1, rsp_word_type'{1'b1, 4'd0, 1'b0, 1'b0}});
      dir_rows.push_back('{32'h0000_0FC0, 1'b1, rsp_word_type'{1'b0, 4'd1, 1'b0, 1'b0}});
      dir_rows.push_back('{32'hFFFF_F000, 1'b1, rsp_word_type'{1'b0, 4'd1, 1'b0, 1'b0}});
      // fill every way of set 1, then two replacements in fill order
      for (int i = 0; i < NUM_WAYS; i++)
         dir_rows.push_back('{{20'h80000 | 20'(i * 20'h0_1111), 6'd1, 6'(i * 4)},
                              1'b0, rsp_word_type'('0)});
      dir_rows.push_back('{{20'h7FFFF, 6'd1, 6'd40}, 1'b1,
                           rsp_word_type'{1'b0, 4'd0, 1'b1, 1'b1}});
      dir_rows.push_back('{{20'h00000, 6'd1, 6'd0}, 1'b1,
                           rsp_word_type'{1'b0, 4'd1, 1'b0, 1'b1}});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_lookup(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].want);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin req_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin req_idle_pct = 65; rcv_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rcv_stall_pct = 65; end
            default: begin req_idle_pct = 19; rcv_stall_pct = 19; end
         endcase
         repeat (PHASE_WORDS)
            send_lookup(pick_addr(), 1'b0, rsp_word_type'('0));
      end

      @(posedge clock);
      req_if.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      // a stray word would show up within the pipeline depth
      repeat (10) @(posedge clock);
      if (err_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #400_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ set_assoc_cache_tags_fifo_top.f @@
hdl/sactf_pkg.sv
hdl/sactf_if.sv
hdl/sactf_ram.sv
hdl/set_assoc_cache_tags_fifo_top.sv
verif/tb_top.sv
